// ----- hdl/tciw_pkg.sv -----
// Shared types and constants for the text console insert writer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tciw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int MAX_TAIL = 127;
    localparam int CELLS    = COLUMNS * ROWS;

    // Scroll moves rows 1..ROWS-2 up; blanking runs to the end of row ROWS-2
    localparam int SCROLL_CELLS = (ROWS - 2) * COLUMNS;
    localparam int SCROLL_LIMIT = (ROWS - 1) * COLUMNS;

    // Widths
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;
    localparam int OP_W     = 3;
    localparam int RADDR_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int RAM_AW   = $clog2(CELLS);
    localparam int TAIL_W   = $clog2(MAX_TAIL + 1);
    localparam int POS_W    = $clog2(CELLS + COLUMNS + MAX_TAIL + 1);
    localparam int CNT_MAX  = (SCROLL_CELLS > MAX_TAIL + 1) ? SCROLL_CELLS : MAX_TAIL + 1;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CHAR_W-1:0]  char_code;
        logic [RADDR_W-1:0] read_address;
    } tciw_in_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_position;
        logic [CELL_W-1:0]   cell_value;
        logic                fault;
    } tciw_out_t;

    // One write port and one read port per cycle
    typedef struct packed {
        logic              wr_en;
        logic [RAM_AW-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [RAM_AW-1:0] rd_addr;
    } tciw_ram_req_t;

    typedef struct packed {
        logic idle;
        logic clearing;
        logic fault;
    } tciw_status_t;

endpackage

`default_nettype wire

// ----- hdl/tciw_screen_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// Depends on tciw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tciw_screen_ram import tciw_pkg::*;
(
    input  wire logic              clk,
    input  wire tciw_ram_req_t     req,
    output logic [CELL_W-1:0]      rd_data_reg
);

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tciw_ctrl.sv -----
// Sequencer for the console writer: clear pass, shift/scroll copy loop,
// newline row search, cursor bookkeeping. Depends on tciw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tciw_ctrl import tciw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire tciw_in_t          req_item,
    input  wire logic [ATTR_W-1:0] attr,
    input  wire logic [CELL_W-1:0] rd_data,
    input  wire logic              res_ready,
    output tciw_ram_req_t          ram_req,
    output logic                   res_valid,
    output tciw_out_t              res,
    output tciw_status_t           status
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_RDWAIT   = 4'd3;
    localparam logic [3:0] ST_NL       = 4'd4;
    localparam logic [3:0] ST_COPY     = 4'd5;
    localparam logic [3:0] ST_PUTW     = 4'd6;
    localparam logic [3:0] ST_CHECK    = 4'd7;
    localparam logic [3:0] ST_BLANK    = 4'd8;
    localparam logic [3:0] ST_TAILW    = 4'd9;
    localparam logic [3:0] ST_FINISH   = 4'd10;

    localparam logic [1:0] CP_RIGHT  = 2'd0;
    localparam logic [1:0] CP_LEFT   = 2'd1;
    localparam logic [1:0] CP_SCROLL = 2'd2;

    localparam logic [POS_W-1:0] CELLS_P  = POS_W'(CELLS);
    localparam logic [POS_W-1:0] COLS_P   = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] LIMIT_P  = POS_W'(SCROLL_LIMIT);
    localparam logic [CNT_W-1:0] SCROLL_N = CNT_W'(SCROLL_CELLS);

    logic [3:0]          state_reg, state_next;
    tciw_in_t            item_reg, item_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]          mode_reg, mode_next;
    logic                pend_reg, pend_next;
    logic                pend_ok_reg, pend_ok_next;
    logic [POS_W-1:0]    pend_dst_reg, pend_dst_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [TAIL_W-1:0]   tail_reg, tail_next;
    logic                fault_reg, fault_next;
    logic [CELL_W-1:0]   value_reg, value_next;

    logic [POS_W-1:0]    cur_pos;
    logic [POS_W-1:0]    tail_pos;
    logic [POS_W-1:0]    raddr_pos;

    assign cur_pos   = POS_W'(cursor_reg);
    assign tail_pos  = pos_reg + POS_W'(tail_reg);
    assign raddr_pos = POS_W'(item_reg.read_address);

    assign res.cursor_position = cursor_reg;
    assign res.cell_value      = value_reg;
    assign res.fault           = fault_reg;

    assign status.idle     = (state_reg == ST_IDLE);
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.fault    = fault_reg;

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        pos_next      = pos_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        pend_next     = pend_reg;
        pend_ok_next  = pend_ok_reg;
        pend_dst_next = pend_dst_reg;
        cursor_next   = cursor_reg;
        tail_next     = tail_reg;
        fault_next    = fault_reg;
        value_next    = value_reg;
        ram_req       = '0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = RAM_AW'(ptr_reg);
                ram_req.wr_data = '0;
                ptr_next        = ptr_reg + POS_W'(1);
                if (ptr_reg == CELLS_P - POS_W'(1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req_item;
                    value_next = '0;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                pos_next   = cur_pos;
                state_next = ST_FINISH;
                if (!fault_reg)
                begin
                    unique case (item_reg.operation)
                        OP_PUT:
                        begin
                            if (item_reg.char_code == NEWLINE_CHAR)
                            begin
                                ptr_next   = '0;
                                state_next = ST_NL;
                            end
                            else if (tail_reg == '0)
                            begin
                                state_next = ST_PUTW;
                            end
                            else
                            begin
                                // shift the tail right, walking down from its end
                                ptr_next   = cur_pos + POS_W'(tail_reg) - POS_W'(1);
                                cnt_next   = CNT_W'(tail_reg);
                                mode_next  = CP_RIGHT;
                                pend_next  = 1'b0;
                                state_next = ST_COPY;
                            end
                        end
                        OP_BACK:
                        begin
                            if (cursor_reg == '0)
                            begin
                                state_next = ST_CHECK;
                            end
                            else
                            begin
                                ptr_next   = cur_pos;
                                cnt_next   = CNT_W'(tail_reg) + CNT_W'(1);
                                mode_next  = CP_LEFT;
                                pend_next  = 1'b0;
                                pos_next   = cur_pos - POS_W'(1);
                                state_next = ST_COPY;
                            end
                        end
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0 && tail_reg != TAIL_W'(MAX_TAIL))
                            begin
                                cursor_next = cursor_reg - CURSOR_W'(1);
                                tail_next   = tail_reg + TAIL_W'(1);
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (tail_reg != '0)
                            begin
                                cursor_next = cursor_reg + CURSOR_W'(1);
                                tail_next   = tail_reg - TAIL_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            ram_req.rd_en   = (raddr_pos < CELLS_P);
                            ram_req.rd_addr = RAM_AW'(item_reg.read_address);
                            pend_ok_next    = (raddr_pos < CELLS_P);
                            state_next      = ST_RDWAIT;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                value_next = pend_ok_reg ? rd_data : '0;
                state_next = ST_FINISH;
            end

            ST_NL:
            begin
                // find the start of the row after the cursor
                if (ptr_reg + COLS_P <= pos_reg)
                begin
                    ptr_next = ptr_reg + COLS_P;
                end
                else
                begin
                    pos_next   = ptr_reg + COLS_P;
                    tail_next  = '0;
                    state_next = ST_CHECK;
                end
            end

            ST_COPY:
            begin
                // read one cell per cycle, write it back in the cycle after
                if (cnt_reg != '0)
                begin
                    ram_req.rd_en   = (ptr_reg < CELLS_P);
                    ram_req.rd_addr = RAM_AW'(ptr_reg);
                    pend_next       = 1'b1;
                    pend_ok_next    = (ptr_reg < CELLS_P);
                    cnt_next        = cnt_reg - CNT_W'(1);
                    unique case (mode_reg)
                        CP_RIGHT:
                        begin
                            pend_dst_next = ptr_reg + POS_W'(1);
                            ptr_next      = ptr_reg - POS_W'(1);
                        end
                        CP_LEFT:
                        begin
                            pend_dst_next = ptr_reg - POS_W'(1);
                            ptr_next      = ptr_reg + POS_W'(1);
                        end
                        default:
                        begin
                            pend_dst_next = ptr_reg - COLS_P;
                            ptr_next      = ptr_reg + POS_W'(1);
                        end
                    endcase
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    ram_req.wr_en   = (pend_dst_reg < CELLS_P);
                    ram_req.wr_addr = RAM_AW'(pend_dst_reg);
                    ram_req.wr_data = pend_ok_reg ? rd_data : '0;
                end

                if (cnt_reg == '0 && !pend_reg)
                begin
                    unique case (mode_reg)
                        CP_RIGHT: state_next = ST_PUTW;
                        CP_LEFT:  state_next = ST_CHECK;
                        default:
                        begin
                            ptr_next   = pos_reg;
                            state_next = ST_BLANK;
                        end
                    endcase
                end
            end

            ST_PUTW:
            begin
                ram_req.wr_en   = (pos_reg < CELLS_P);
                ram_req.wr_addr = RAM_AW'(pos_reg);
                ram_req.wr_data = {attr, item_reg.char_code};
                pos_next        = pos_reg + POS_W'(1);
                state_next      = ST_CHECK;
            end

            ST_CHECK:
            begin
                priority if (pos_reg > CELLS_P)
                begin
                    fault_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (pos_reg >= LIMIT_P)
                begin
                    ptr_next   = COLS_P;
                    cnt_next   = SCROLL_N;
                    mode_next  = CP_SCROLL;
                    pend_next  = 1'b0;
                    pos_next   = pos_reg - COLS_P;
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_TAILW;
                end
            end

            ST_BLANK:
            begin
                if (ptr_reg < LIMIT_P)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = RAM_AW'(ptr_reg);
                    ram_req.wr_data = '0;
                    ptr_next        = ptr_reg + POS_W'(1);
                end
                else
                begin
                    state_next = ST_TAILW;
                end
            end

            ST_TAILW:
            begin
                cursor_next     = CURSOR_W'(pos_reg);
                ram_req.wr_en   = (tail_pos < CELLS_P);
                ram_req.wr_addr = RAM_AW'(tail_pos);
                ram_req.wr_data = {attr, SPACE_CHAR};
                state_next      = ST_FINISH;
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            cursor_reg <= '0;
            tail_reg   <= '0;
            fault_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            cursor_reg <= cursor_next;
            tail_reg   <= tail_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pos_reg      <= pos_next;
        mode_reg     <= mode_next;
        pend_ok_reg  <= pend_ok_next;
        pend_dst_reg <= pend_dst_next;
        value_reg    <= value_next;
    end

endmodule

`default_nettype wire

// ----- hdl/text_console_insert_writer.sv -----
// Top level of the text console insert writer: attribute register, screen
// RAM, sequencer and result register. Depends on tciw_pkg, tciw_screen_ram, tciw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload     Role
// req       req_valid/req_stall    tciw_in_t   command item in
// rsp       rsp_valid/rsp_stall    tciw_out_t  one result item per command
// cfg       cfg_we                 cfg_data    text attribute write, no read-back
//
// A put with a tail first shifts the tail right, a backspace shifts it left, and a newline
// searches for the start of the next row. A scroll adds a copy loop (one cell per cycle
// through the RAM's single read port) and a blanking pass to the end of row ROWS-2.
// Reset: the RAM is cleared one cell per cycle, with req_stall high; cfg writes are
// taken during that pass.
// Stalls: rsp is a registered output; one finished item may wait in it while the
// next is accepted and worked on. The sequencer holds at its last step until that
// register is free.

module text_console_insert_writer import tciw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire tciw_in_t          req_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tciw_out_t              rsp_item,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_data
);

    logic [ATTR_W-1:0] attr_reg;     // attribute byte for written cells
    logic              rsp_valid_reg;
    tciw_out_t         rsp_item_reg;

    tciw_ram_req_t     ram_req;
    logic [CELL_W-1:0] ram_rd_data;
    logic              res_valid;
    tciw_out_t         res;
    tciw_status_t      status;
    logic              out_free;

    // output register empty, or its item leaves this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !status.idle;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            rsp_item_reg <= res;
        end
    end

    tciw_screen_ram u_ram
    (
        .clk         (clk),
        .req         (ram_req),
        .rd_data_reg (ram_rd_data)
    );

    tciw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_item  (req_item),
        .attr      (attr_reg),
        .rd_data   (ram_rd_data),
        .res_ready (out_free),
        .ram_req   (ram_req),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // fault is sticky until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.fault |=> status.fault)
        else $error("fault flag dropped");

    // every RAM write lands inside the screen
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> (ram_req.wr_addr < RAM_AW'(CELLS)))
        else $error("RAM write outside screen");

    // copy loop never reads a cell in the cycle it is written
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
        else $error("RAM read and write at one address");

    // no result is offered while the screen is still being cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !res_valid && !(rsp_valid_reg && $past(status.clearing) &&
                                            !$past(rsp_valid_reg)))
        else $error("result during clear pass");

endmodule

`default_nettype wire
